FILE: sv/chained_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Chained hash table assertion macros
// Shorthand for the clocked, reset-qualified assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define CHT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, clocked on clk and disabled in reset.
`define CHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Operation and status codes, state types and hash constants.
// ----------------------------------------------------------------------------
package cht_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DUMP   = 2'd2
	} cht_op_e;

	typedef enum logic [2:0] {
		ST_INSERTED   = 3'd0,
		ST_UPDATED    = 3'd1,
		ST_FOUND      = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_DROPPED    = 3'd4,
		ST_DUMP_ENTRY = 3'd5,
		ST_DUMP_EMPTY = 3'd6
	} cht_status_e;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_MIX,
		FR_MUL,
		FR_MOD,
		FR_PUSH
	} cht_front_e;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD_WAIT,
		BK_NODE_WAIT,
		BK_DUMP_SCAN,
		BK_DUMP_HEAD,
		BK_DUMP_NODE
	} cht_back_e;

	typedef struct packed {
		cht_op_e     op;
		logic [30:0] key;
	} cht_cmd_t;

	localparam int          KEY_BITS     = 31;
	localparam int          HASH_BITS    = 32;
	localparam logic [31:0] WANG_XOR     = 32'd61;
	localparam int          WANG_SH_A    = 16;
	localparam int          WANG_SH_B    = 3;
	localparam int          WANG_SH_C    = 4;
	localparam logic [31:0] WANG_MUL     = 32'h27d4eb2d;
	localparam int          WANG_SH_D    = 15;
	localparam logic [7:0]  ZERO_BUCKETS = 8'd100;
	localparam int          MOD_BITS     = 4;
	localparam int          MOD_CYCLES   = HASH_BITS / MOD_BITS;
	localparam logic [2:0]  REG_BUCKET_COUNT = 3'd0;

endpackage

FILE: sv/chained_hash_table.sv
// ----------------------------------------------------------------------------
// Chained hash table
// Key-to-payload table with separately chained buckets and a dump operation.
// ----------------------------------------------------------------------------
// An item is hashed after it is taken (multiplier and a 4-bit-per-cycle modulo unit) and
// then queued; no new item is taken until the last one has been queued. Insert and lookup
// results follow the bucket head read and each chain node visited; a dump gives one result
// per node, scanning the buckets in order. Results cannot be stalled. Reset empties
// every bucket at once through per-bucket valid bits and sets the bucket count to 100.
module chained_hash_table import cht_pkg::*; #(
	parameter int MAX_BUCKETS  = 128,
	parameter int MAX_NODES    = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [KEY_BITS-1:0]     key,
	input  logic [PAYLOAD_BITS-1:0] payload,
	output logic                    strobe,
	output logic [2:0]              status,
	output logic [KEY_BITS-1:0]     out_key,
	output logic [PAYLOAD_BITS-1:0] out_payload,
	output logic [6:0]              entry_total,
	output logic                    last,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int BW = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;

	logic [7:0]              bucket_count_q;
	logic                    q_valid, q_pop;
	cht_cmd_t                q_cmd;
	logic [PAYLOAD_BITS-1:0] q_payload;
	logic [BW-1:0]           q_bucket;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_BUCKET_COUNT) ? {24'd0, bucket_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= ZERO_BUCKETS;
		end else if (psel && penable && pwrite && paddr == REG_BUCKET_COUNT) begin
			bucket_count_q <= pwdata[7:0];
		end
	end

	cht_front #(.PAYLOAD_BITS(PAYLOAD_BITS), .MAX_BUCKETS(MAX_BUCKETS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .key(key),
		.payload(payload), .bucket_count(bucket_count_q), .busy(busy),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_payload(q_payload),
		.q_bucket(q_bucket), .q_pop(q_pop)
	);

	cht_back #(
		.MAX_BUCKETS(MAX_BUCKETS), .MAX_NODES(MAX_NODES), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd),
		.q_payload(q_payload), .q_bucket(q_bucket), .q_pop(q_pop),
		.strobe(strobe), .status(status), .out_key(out_key),
		.out_payload(out_payload), .entry_total(entry_total), .last(last)
	);

endmodule

FILE: sv/cht_ram.sv
// ----------------------------------------------------------------------------
// Chained hash table RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/cht_front.sv
// ----------------------------------------------------------------------------
// Chained hash table front end
// Accepts items, hashes the key, reduces it to a bucket and queues the item.
// ----------------------------------------------------------------------------
module cht_front import cht_pkg::*; #(
	parameter int PAYLOAD_BITS = 32,
	parameter int MAX_BUCKETS  = 128
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [1:0]                                   op,
	input  logic [KEY_BITS-1:0]                          key,
	input  logic [PAYLOAD_BITS-1:0]                      payload,
	input  logic [7:0]                                   bucket_count,
	output logic                                         busy,
	output logic                                         q_valid,
	output cht_cmd_t                                     q_cmd,
	output logic [PAYLOAD_BITS-1:0]                      q_payload,
	output logic [(MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1)-1:0] q_bucket,
	input  logic                                         q_pop
);

	localparam int BW  = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
	localparam int NBW = $clog2(MAX_BUCKETS + 1);
	localparam int CTW = $clog2(MOD_CYCLES);

	cht_front_e state_q, state_d;

	cht_cmd_t                cmd_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [HASH_BITS-1:0]    h_q;
	logic [NBW-1:0]          n_q;
	logic [NBW-1:0]          r_q;
	logic [CTW-1:0]          cnt_q;

	logic [HASH_BITS-1:0] k0, h0, h1, h2;
	logic [7:0]           nraw;
	logic [NBW-1:0]       n_d;
	logic [NBW-1:0]       r_d;
	logic [NBW:0]         tt;
	logic                 take, push, full;

	cht_cmd_t                fq_cmd [2];
	logic [PAYLOAD_BITS-1:0] fq_pay [2];
	logic [BW-1:0]           fq_bkt [2];
	logic                    wp_q, rp_q;
	logic [1:0]              fcnt_q;

	always_comb begin
		k0 = {1'b0, key};
		h0 = (k0 ^ WANG_XOR) ^ (k0 >> WANG_SH_A);
		h1 = h0 + (h0 << WANG_SH_B);
		h2 = h_q ^ (h_q >> WANG_SH_C);
		nraw = (bucket_count == 8'd0) ? ZERO_BUCKETS : bucket_count;
		if (32'(nraw) > MAX_BUCKETS) begin
			n_d = NBW'(MAX_BUCKETS);
		end else begin
			n_d = NBW'(nraw);
		end
	end

	always_comb begin
		r_d = r_q;
		tt  = '0;
		for (int i = 0; i < MOD_BITS; i++) begin
			tt = {r_d, h_q[HASH_BITS-1-i]};
			if (tt >= {1'b0, n_q}) begin
				tt = tt - {1'b0, n_q};
			end
			r_d = tt[NBW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (start && (op inside {OP_INSERT, OP_LOOKUP, OP_DUMP})) begin
					state_d = FR_MIX;
				end
			end
			FR_MIX:  state_d = FR_MUL;
			FR_MUL:  state_d = FR_MOD;
			FR_MOD: begin
				if (cnt_q == CTW'(MOD_CYCLES - 1)) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				if (!full) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		full = (fcnt_q == 2'd2);
		busy = (state_q != FR_IDLE);
		take = (state_q == FR_IDLE) && start;
		push = (state_q == FR_PUSH) && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FR_IDLE: begin
				if (take) begin
					cmd_q.op  <= cht_op_e'(op);
					cmd_q.key <= key;
					pay_q     <= payload;
					h_q       <= h1;
					n_q       <= n_d;
				end
			end
			FR_MIX: h_q <= h2 * WANG_MUL;
			FR_MUL: begin
				h_q   <= h_q ^ (h_q >> WANG_SH_D);
				r_q   <= '0;
				cnt_q <= '0;
			end
			FR_MOD: begin
				r_q   <= r_d;
				h_q   <= h_q << MOD_BITS;
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fq_cmd[wp_q] <= cmd_q;
			fq_pay[wp_q] <= pay_q;
			fq_bkt[wp_q] <= BW'(r_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fcnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop && q_valid) begin
				rp_q <= ~rp_q;
			end
			fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

	assign q_valid   = (fcnt_q != 2'd0);
	assign q_cmd     = fq_cmd[rp_q];
	assign q_payload = fq_pay[rp_q];
	assign q_bucket  = fq_bkt[rp_q];

endmodule

FILE: sv/cht_back.sv
// ----------------------------------------------------------------------------
// Chained hash table back end
// Walks bucket chains in the node store, inserts, looks up and dumps entries.
// ----------------------------------------------------------------------------
module cht_back import cht_pkg::*; #(
	parameter int MAX_BUCKETS  = 128,
	parameter int MAX_NODES    = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         q_valid,
	input  cht_cmd_t                                     q_cmd,
	input  logic [PAYLOAD_BITS-1:0]                      q_payload,
	input  logic [(MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1)-1:0] q_bucket,
	output logic                                         q_pop,
	output logic                                         strobe,
	output logic [2:0]                                   status,
	output logic [KEY_BITS-1:0]                          out_key,
	output logic [PAYLOAD_BITS-1:0]                      out_payload,
	output logic [6:0]                                   entry_total,
	output logic                                         last
);

	localparam int BW = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
	localparam int NW = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam logic [NW:0] NO_NODE = (NW+1)'(MAX_NODES);

	cht_back_e state_q, state_d;

	cht_op_e                 op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [BW-1:0]           bkt_q;
	logic                    hv_cap_q;
	logic [NW:0]             hd_q;
	logic [NW-1:0]           p_q;
	logic [BW-1:0]           di_q;
	logic [CW-1:0]           dk_q;
	logic [CW-1:0]           count_q, count_d;
	logic [MAX_BUCKETS-1:0]  hv_q;

	logic                    h_we, h_re;
	logic [BW-1:0]           h_ra;
	logic [NW-1:0]           h_rd;
	logic                    new_we, pay_we, n_re;
	logic [NW-1:0]           n_wa, n_ra;
	logic [KEY_BITS-1:0]     key_rd;
	logic [PAYLOAD_BITS-1:0] pay_rd;
	logic [NW:0]             lk_rd;

	logic [NW:0]             hp, hd_cur;
	logic                    hit, miss, dlast, full;
	logic                    e_valid, e_last;
	cht_status_e             e_status;
	logic [KEY_BITS-1:0]     e_key;
	logic [PAYLOAD_BITS-1:0] e_pay;

	cht_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .waddr(bkt_q), .wdata(count_q[NW-1:0]),
		.re(h_re), .raddr(h_ra), .rdata(h_rd)
	);

	cht_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_NODES)) u_keys (
		.clk(clk), .we(new_we), .waddr(n_wa), .wdata(key_q),
		.re(n_re), .raddr(n_ra), .rdata(key_rd)
	);

	cht_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(MAX_NODES)) u_pays (
		.clk(clk), .we(new_we || pay_we), .waddr(n_wa), .wdata(pay_q),
		.re(n_re), .raddr(n_ra), .rdata(pay_rd)
	);

	cht_ram #(.WIDTH(NW+1), .DEPTH(MAX_NODES)) u_links (
		.clk(clk), .we(new_we), .waddr(n_wa), .wdata(hd_cur),
		.re(n_re), .raddr(n_ra), .rdata(lk_rd)
	);

	always_comb begin
		hp     = hv_cap_q ? {1'b0, h_rd} : NO_NODE;
		hd_cur = (state_q == BK_HEAD_WAIT) ? hp : hd_q;
		full   = (count_q >= CW'(MAX_NODES));
		dlast  = (CW'(dk_q + 1'b1) == count_q);
		hit    = (state_q == BK_NODE_WAIT) && (key_rd == key_q);
		miss   = ((state_q == BK_HEAD_WAIT) && (hp >= NO_NODE)) ||
		         ((state_q == BK_NODE_WAIT) && (key_rd != key_q) && (lk_rd >= NO_NODE));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (q_cmd.op == OP_DUMP) begin
						state_d = (count_q == '0) ? BK_IDLE : BK_DUMP_SCAN;
					end else begin
						state_d = BK_HEAD_WAIT;
					end
				end
			end
			BK_HEAD_WAIT: state_d = miss ? BK_IDLE : BK_NODE_WAIT;
			BK_NODE_WAIT: begin
				if (hit || miss) begin
					state_d = BK_IDLE;
				end
			end
			BK_DUMP_SCAN: begin
				if (hv_q[di_q]) begin
					state_d = BK_DUMP_HEAD;
				end
			end
			BK_DUMP_HEAD: state_d = BK_DUMP_NODE;
			BK_DUMP_NODE: begin
				if (dlast) begin
					state_d = BK_IDLE;
				end else if (lk_rd >= NO_NODE) begin
					state_d = BK_DUMP_SCAN;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		h_we     = 1'b0;
		h_re     = 1'b0;
		h_ra     = q_bucket;
		new_we   = 1'b0;
		pay_we   = 1'b0;
		n_re     = 1'b0;
		n_ra     = p_q;
		n_wa     = p_q;
		count_d  = count_q;
		e_valid  = 1'b0;
		e_status = ST_NOT_FOUND;
		e_key    = key_q;
		e_pay    = '0;
		e_last   = 1'b1;
		case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_cmd.op != OP_DUMP) begin
					h_re = 1'b1;
				end
				if (q_valid && q_cmd.op == OP_DUMP && count_q == '0) begin
					e_valid  = 1'b1;
					e_status = ST_DUMP_EMPTY;
					e_key    = '0;
				end
			end
			BK_HEAD_WAIT: begin
				if (!miss) begin
					n_re = 1'b1;
					n_ra = hp[NW-1:0];
				end
			end
			BK_NODE_WAIT: begin
				if (!hit && !miss) begin
					n_re = 1'b1;
					n_ra = lk_rd[NW-1:0];
				end
			end
			BK_DUMP_SCAN: begin
				h_ra = di_q;
				h_re = hv_q[di_q];
			end
			BK_DUMP_HEAD: begin
				n_re = 1'b1;
				n_ra = h_rd;
			end
			BK_DUMP_NODE: begin
				e_valid  = 1'b1;
				e_status = ST_DUMP_ENTRY;
				e_key    = key_rd;
				e_pay    = pay_rd;
				e_last   = dlast;
				if (!dlast && lk_rd < NO_NODE) begin
					n_re = 1'b1;
					n_ra = lk_rd[NW-1:0];
				end
			end
			default: ;
		endcase
		if (hit || miss) begin
			e_valid = 1'b1;
			if (op_q == OP_INSERT) begin
				if (hit) begin
					pay_we   = 1'b1;
					e_status = ST_UPDATED;
					e_pay    = pay_q;
				end else if (full) begin
					e_status = ST_DROPPED;
				end else begin
					new_we   = 1'b1;
					h_we     = 1'b1;
					n_wa     = count_q[NW-1:0];
					count_d  = count_q + 1'b1;
					e_status = ST_INSERTED;
					e_pay    = pay_q;
				end
			end else if (hit) begin
				e_status = ST_FOUND;
				e_pay    = pay_rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			hv_q    <= '0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			strobe  <= e_valid;
			if (h_we) begin
				hv_q[bkt_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (e_valid) begin
			status      <= e_status;
			out_key     <= e_key;
			out_payload <= e_pay;
			entry_total <= 7'(count_d);
			last        <= e_last;
		end
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					op_q     <= q_cmd.op;
					key_q    <= q_cmd.key;
					pay_q    <= q_payload;
					bkt_q    <= q_bucket;
					hv_cap_q <= hv_q[q_bucket];
					di_q     <= '0;
					dk_q     <= '0;
				end
			end
			BK_HEAD_WAIT: begin
				hd_q <= hp;
				p_q  <= hp[NW-1:0];
			end
			BK_NODE_WAIT: begin
				if (n_re) begin
					p_q <= lk_rd[NW-1:0];
				end
			end
			BK_DUMP_SCAN: begin
				if (!hv_q[di_q]) begin
					di_q <= di_q + 1'b1;
				end
			end
			BK_DUMP_NODE: begin
				dk_q <= dk_q + 1'b1;
				if (lk_rd >= NO_NODE) begin
					di_q <= di_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/cht_checker.sv
// ----------------------------------------------------------------------------
// Chained hash table checker
// Port-level properties of results and acceptance, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_table_macros.svh"

module cht_checker import cht_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] op,
	input logic       strobe,
	input logic [2:0] status,
	input logic [6:0] entry_total,
	input logic       last
);

	`CHT_ASSERT_NEXT(a_busy_after_take, start && !busy && (op == OP_INSERT || op == OP_LOOKUP || op == OP_DUMP), busy)
	`CHT_ASSERT_IMP(a_single_last, strobe && status != ST_DUMP_ENTRY, last)
	`CHT_ASSERT_IMP(a_insert_counted, strobe && status == ST_INSERTED, entry_total != 7'd0)
	`CHT_ASSERT_IMP(a_empty_dump_zero, strobe && status == ST_DUMP_EMPTY, entry_total == 7'd0)

endmodule

bind chained_hash_table cht_checker u_cht_checker (.*);
